[hw/rtl/assert_macros.svh]
// Assertion macros for the checker module of the table search block.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define STBS_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define STBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[hw/rtl/stbs_pkg.sv]
// Shared types and field widths for the sorted table search block.
// No dependencies; imported by the controller, the top level and the checker.
package stbs_pkg;

    localparam int CFG_W   = 11;  // table_length register
    localparam int IDX_W   = 10;  // entry_index / found_index fields
    localparam int VAL_W   = 32;  // value / found_value fields

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ORDER_DECR  = 2'd0,
        ORDER_INCR  = 2'd1,
        ORDER_CONST = 2'd2
    } t_order;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_DONE
    } t_state;

    // Finished search result handed from the controller to the output stage
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        t_order           order;
    } t_result;

endpackage

[hw/rtl/stbs_table.sv]
// Table storage: one write port, one read port with registered read data.
// No package dependencies; instantiated by the top level.
module stbs_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [ENTRY_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [ENTRY_WIDTH-1:0] o_rdata
);

    logic [ENTRY_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/stbs_ctrl.sv]
// Search sequencer: order check from first/last entry, then one probe per cycle.
// Depends on stbs_pkg; drives the table read address and hands back a t_result.
module stbs_ctrl import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,         // search request accepted
    input  logic [ENTRY_WIDTH-1:0] i_key,
    input  logic [CFG_W-1:0]       i_table_length,
    input  logic [ENTRY_WIDTH-1:0] i_rdata,
    input  logic                   i_take,          // output stage takes the result
    output logic [AW-1:0]          o_raddr,
    output logic                   o_idle,
    output t_result                o_result
);

    localparam int BW = AW + 1;

    t_state                 r_state, n_state;
    logic [ENTRY_WIDTH-1:0] r_key, r_first, r_value;
    logic [BW-1:0]          r_last, r_low, r_high;
    logic [AW-1:0]          r_mid, r_pos;
    logic                   r_found;
    t_order                 r_order;

    logic [31:0]            len32, use_len;
    logic [BW-1:0]          last_idx;
    t_order                 cls_order;
    logic [BW-1:0]          mid_bw, nl, nh;
    logic [BW:0]            msum;
    logic [AW-1:0]          next_mid;
    logic                   eq, go_up, miss;
    logic [31:0]            pos32;
    logic [63:0]            val64;

    // length in use: zero reads as one, saturate at the table depth
    always_comb begin
        len32 = 32'(i_table_length);
        if (len32 == 32'd0) begin
            use_len = 32'd1;
        end else if (len32 > 32'(TABLE_DEPTH)) begin
            use_len = 32'(TABLE_DEPTH);
        end else begin
            use_len = len32;
        end
        last_idx = BW'(use_len - 32'd1);
    end

    // classify from first entry (registered) and last entry (on read data)
    always_comb begin
        if (r_first > i_rdata) begin
            cls_order = ORDER_DECR;
        end else if (r_first < i_rdata) begin
            cls_order = ORDER_INCR;
        end else begin
            cls_order = ORDER_CONST;
        end
    end

    // shared probe unit: compare, bound update, next midpoint
    always_comb begin
        mid_bw = {1'b0, r_mid};
        eq     = (i_rdata == r_key);
        go_up  = (r_order == ORDER_INCR) ? (r_key > i_rdata) : (r_key < i_rdata);
        if (go_up) begin
            nl = mid_bw + BW'(1);
            nh = r_high;
        end else begin
            nl = r_low;
            nh = mid_bw - BW'(1);
        end
        // stepping below index zero ends the search
        miss     = (!go_up && (r_mid == '0)) || (nl > nh);
        msum     = {1'b0, nl} + {1'b0, nh};
        next_mid = msum[AW:1];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_FIRST;
            ST_FIRST: n_state = ST_LAST;
            ST_LAST:  n_state = (cls_order == ORDER_CONST) ? ST_DONE : ST_PROBE;
            ST_PROBE: if (eq || miss) n_state = ST_DONE;
            ST_DONE:  if (i_take) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs: read address per state, idle flag, result
    always_comb begin
        unique case (r_state)
            ST_IDLE:  o_raddr = '0;
            ST_FIRST: o_raddr = r_last[AW-1:0];
            ST_LAST:  o_raddr = r_last[AW:1];
            ST_PROBE: o_raddr = next_mid;
            ST_DONE:  o_raddr = '0;
            default:  o_raddr = '0;
        endcase
        o_idle = (r_state == ST_IDLE);

        pos32          = 32'(r_pos);
        val64          = 64'(r_value);
        o_result.valid = (r_state == ST_DONE);
        o_result.found = r_found;
        o_result.index = r_found ? pos32[IDX_W-1:0] : '0;
        o_result.value = r_found ? val64[VAL_W-1:0] : '0;
        o_result.order = r_order;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_key  <= i_key;
                    r_last <= last_idx;
                end
            end
            ST_FIRST: begin
                r_first <= i_rdata;
            end
            ST_LAST: begin
                r_order <= cls_order;
                if (cls_order == ORDER_CONST) begin
                    r_found <= (r_first == r_key);
                    r_pos   <= '0;
                    r_value <= r_first;
                end else begin
                    r_low  <= '0;
                    r_high <= r_last;
                    r_mid  <= r_last[AW:1];
                end
            end
            ST_PROBE: begin
                if (eq) begin
                    r_found <= 1'b1;
                    r_pos   <= r_mid;
                    r_value <= i_rdata;
                end else if (miss) begin
                    r_found <= 1'b0;
                end else begin
                    r_low  <= nl;
                    r_high <= nh;
                    r_mid  <= next_mid;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/sorted_table_binary_search_top.sv]
// A search reads the first and last entries, then makes P probes with P <=
// floor(log2(length)) + 1 (0 for a constant table); its result is registered
// for o_valid; no request is taken until then. The single table read port sets
// one probe per cycle. Writes are taken every cycle while no search is running.
// Reset (synchronous, active low) clears control and sets table_length to 1; the
// table contents are not cleared.
module sorted_table_binary_search_top import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    // request channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [VAL_W-1:0] i_value,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_found,
    output logic [IDX_W-1:0] o_found_index,
    output logic [VAL_W-1:0] o_found_value,
    output logic [1:0]       o_table_order
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [CFG_W-1:0]       r_table_length;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_acc, ctrl_idle, take, mem_we;
    logic [31:0]            idx32;
    logic [63:0]            val64;
    logic [ENTRY_WIDTH-1:0] entry_val, rdata;
    logic [AW-1:0]          raddr;
    t_result                result;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_table_length <= i_cfg_data;
        end
    end

    // request accept and table write decode
    assign o_stall   = !ctrl_idle;
    assign in_acc    = i_valid && !o_stall;
    assign idx32     = 32'(i_entry_index);
    assign val64     = 64'(i_value);
    assign entry_val = val64[ENTRY_WIDTH-1:0];
    assign mem_we    = in_acc && (t_op'(i_operation) == OP_WRITE)
                       && (idx32 < 32'(TABLE_DEPTH));

    stbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx32[AW-1:0]),
        .i_wdata (entry_val),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_acc && (t_op'(i_operation) == OP_SEARCH)),
        .i_key          (entry_val),
        .i_table_length (r_table_length),
        .i_rdata        (rdata),
        .i_take         (take),
        .o_raddr        (raddr),
        .o_idle         (ctrl_idle),
        .o_result       (result)
    );

    // output register: frees the sequencer while a result waits downstream
    assign take = result.valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out.found;
    assign o_found_index = r_out.index;
    assign o_found_value = r_out.value;
    assign o_table_order = r_out.order;

endmodule

[hw/rtl/stbs_checker.sv]
// Port-level checks for the table search top, attached by bind.
// Depends on stbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stbs_checker import stbs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_operation,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_found,
    input logic [IDX_W-1:0] o_found_index,
    input logic [VAL_W-1:0] o_found_value,
    input logic [1:0]       o_table_order
);

    // stalled result holds
    `STBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_found) && $stable(o_found_index) && $stable(o_found_value) && $stable(o_table_order), "stalled result changed")

    // a miss reports zero index and value
    `STBS_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_found_index == '0 && o_found_value == '0, "miss with nonzero index or value")

    // a hit in a constant table is always at entry zero
    `STBS_ASSERT_NOW(a_const_hit, i_clk, i_rst_n, o_valid && o_found && o_table_order == ORDER_CONST, o_found_index == '0, "constant table hit not at entry zero")

    // a search request occupies the block
    `STBS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, i_valid && !o_stall && i_operation == OP_SEARCH, o_stall, "search accepted without busy")

    // a write request leaves the block free
    `STBS_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, i_valid && !o_stall && i_operation == OP_WRITE, !o_stall, "write request stalled the block")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (.*);

[tb/tb_sorted_table_binary_search_top.sv]
// Testbench for sorted_table_binary_search_top: table writes and key searches under
// several idle and stall mixes, each search result checked against its own lookup.
// Depends on stbs_pkg and the RTL top level; holds a small answer-checking class.
module tb_sorted_table_binary_search_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stbs_pkg::*;

    localparam int          DEPTH          = 1024;
    localparam int          RESULT_SETTLE  = 20;      // longest search makes 11 probes
    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          RANDOM_ITEMS   = 200;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    typedef enum {SHAPE_INCR, SHAPE_DECR, SHAPE_CONST, SHAPE_UNSORTED} t_table_shape;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        t_order           order;
    } t_search_answer;

    // Mirror of the table and length register, plus the answers still owed
    class search_answer_checker;
        logic [VAL_W-1:0] entry_copy [DEPTH];
        logic [CFG_W-1:0] length_reg;
        t_search_answer   pending_answers [$];
        int               failures;

        function new();
            length_reg = 1;
            failures   = 0;
        endfunction

        // Length zero reads as one, anything past the table saturates
        function int used_entries();
            if (length_reg == 0) return 1;
            if (length_reg > DEPTH) return DEPTH;
            return int'(length_reg);
        endfunction

        // Order check on first/last entry, then floor-midpoint probing
        function t_search_answer lookup_answer(logic [VAL_W-1:0] key);
            t_search_answer   ans;
            int               n, lo, hi, mid;
            logic [VAL_W-1:0] first_e, last_e, probe;
            bit               go_up;
            n         = used_entries();
            first_e   = entry_copy[0];
            last_e    = entry_copy[n-1];
            ans.found = 1'b0;
            ans.index = '0;
            ans.value = '0;
            if (first_e > last_e) ans.order = ORDER_DECR;
            else if (first_e < last_e) ans.order = ORDER_INCR;
            else ans.order = ORDER_CONST;
            if (ans.order == ORDER_CONST) begin
                if (first_e == key) begin
                    ans.found = 1'b1;
                    ans.value = first_e;
                end
                return ans;
            end
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
                mid   = (lo + hi) / 2;
                probe = entry_copy[mid];
                if (probe == key) begin
                    ans.found = 1'b1;
                    ans.index = IDX_W'(mid);
                    ans.value = probe;
                    return ans;
                end
                go_up = (ans.order == ORDER_INCR) ? (key > probe) : (key < probe);
                if (go_up) lo = mid + 1;
                else if (mid == 0) return ans;   // would step below entry 0
                else hi = mid - 1;
            end
            return ans;
        endfunction

        function void note_request(t_op op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
            if (op == OP_WRITE) entry_copy[idx] = val;
            else pending_answers.push_back(lookup_answer(val));
        endfunction

        function void check_answer(logic found, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] val, logic [1:0] order);
            t_search_answer want;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: found %0d index %0d value %h order %0d",
                       found, idx, val, order);
                failures++;
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                failures++;
            end
            if (idx !== want.index) begin
                $error("found_index: expected %0d, got %0d", want.index, idx);
                failures++;
            end
            if (val !== want.value) begin
                $error("found_value: expected %h, got %h", want.value, val);
                failures++;
            end
            if (order !== want.order) begin
                $error("table_order: expected %0d, got %0d", want.order, order);
                failures++;
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             i_valid       = 1'b0;
    logic             o_stall;
    logic             i_operation   = 1'b0;
    logic [IDX_W-1:0] i_entry_index = '0;
    logic [VAL_W-1:0] i_value       = '0;
    logic             o_valid;
    logic             i_stall       = 1'b0;
    logic             o_found;
    logic [IDX_W-1:0] o_found_index;
    logic [VAL_W-1:0] o_found_value;
    logic [1:0]       o_table_order;

    // Idle knobs, set per phase by the stimulus
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_ask    = 0;
    int holdoff_taken  = 0;
    int holdoff_left   = 0;

    search_answer_checker answers;

    always #5 i_clk = ~i_clk;

    sorted_table_binary_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_found_value (o_found_value),
        .o_table_order (o_table_order)
    );

    // Result side stall: random, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_ask != holdoff_taken) begin
            holdoff_taken <= holdoff_ask;
            holdoff_left  <= HOLDOFF_CYCLES - 1;
            i_stall       <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            answers.check_answer(o_found, o_found_index, o_found_value, o_table_order);
    end

    // Run limit
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sorted_table_binary_search_top verification failed");
        $finish;
    end

    // One request; valid stays up after acceptance so back-to-back requests need no gap
    task automatic push_request(t_op op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_value       <= val;
        do @(posedge i_clk); while (o_stall);
        answers.note_request(op, idx, val);
    endtask

    task automatic wait_all_answers();
        i_valid <= 1'b0;
        while (answers.pending_answers.size() != 0) @(posedge i_clk);
        repeat (RESULT_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_table_length(logic [CFG_W-1:0] len);
        wait_all_answers();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        answers.length_reg = len;
    endtask

    // Fill entries 0..n-1 with a table of the given shape
    task automatic load_table(int n, t_table_shape shape);
        logic [VAL_W-1:0] vals [DEPTH];
        longint unsigned  total, max_step;
        logic [VAL_W-1:0] base;
        bit               dense;
        dense    = ($urandom_range(99) < 30);    // dense steps give duplicate runs
        max_step = dense ? 3 : ((n > 1) ? 64'hFFFF_FFFF / (n - 1) : 64'hFFFF_FFFF);
        total    = 0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) total += $urandom_range(32'(max_step));
            vals[i] = VAL_W'(total);
        end
        base = $urandom_range(32'(64'hFFFF_FFFF - total));
        for (int i = 0; i < n; i++) begin
            case (shape)
                SHAPE_INCR:  vals[i] = base + vals[i];
                SHAPE_DECR:  vals[i] = ~(base + vals[i]);
                SHAPE_CONST: vals[i] = base;
                default:     vals[i] = $urandom;
            endcase
        end
        for (int i = 0; i < n; i++) push_request(OP_WRITE, IDX_W'(i), vals[i]);
    endtask

    // Entry value that follows the index, flipped for a decreasing table
    function automatic logic [VAL_W-1:0] spine_value(int i, bit dec);
        logic [VAL_W-1:0] v;
        v = {IDX_W'(i), 22'h1};
        return dec ? ~v : v;
    endfunction

    // Full-depth table with only the outer probe paths written: every key used
    // walks the left or right edge of the search, down to entry 0 or up to the end
    task automatic spine_test(logic [CFG_W-1:0] len, bit dec);
        int spine [20];
        for (int j = 0; j < 10; j++) spine[j] = (512 >> j) - 1;
        for (int j = 0; j < 9; j++) spine[10 + j] = (DEPTH - 1) - (256 >> j);
        spine[19] = DEPTH - 1;
        write_table_length(len);
        for (int j = 0; j < 20; j++)
            push_request(OP_WRITE, IDX_W'(spine[j]), spine_value(spine[j], dec));
        for (int j = 0; j < 20; j++)
            push_request(OP_SEARCH, '0, spine_value(spine[j], dec));
        push_request(OP_SEARCH, '0, '0);
        push_request(OP_SEARCH, '0, '1);
    endtask

    // Keys near table contents, the value extremes, or anything
    function automatic logic [VAL_W-1:0] pick_key(int n);
        logic [VAL_W-1:0] e;
        int               roll;
        e    = answers.entry_copy[$urandom_range(n - 1)];
        roll = $urandom_range(99);
        if (roll < 40) return e;
        if (roll < 50) return e + 1;
        if (roll < 60) return e - 1;
        if (roll < 70) return '0;
        if (roll < 80) return '1;
        return $urandom;
    endfunction

    initial begin
        int               phase, random_items, n, count, roll;
        t_table_shape     shape;
        logic [CFG_W-1:0] len;
        answers = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: length 1 after reset, constant table
        push_request(OP_WRITE, '0, 32'h0000_0000);
        push_request(OP_SEARCH, '1, 32'h0000_0000);
        push_request(OP_SEARCH, '0, 32'hFFFF_FFFF);
        // Length zero behaves as one
        write_table_length('0);
        push_request(OP_WRITE, '0, 32'hFFFF_FFFF);
        push_request(OP_SEARCH, '0, 32'hFFFF_FFFF);
        push_request(OP_SEARCH, '1, 32'h0000_0000);
        // Increasing table of four: hits at both ends, miss below all, miss between
        write_table_length(11'd4);
        push_request(OP_WRITE, 10'd0, 32'd5);
        push_request(OP_WRITE, 10'd1, 32'd10);
        push_request(OP_WRITE, 10'd2, 32'd20);
        push_request(OP_WRITE, 10'd3, 32'hFFFF_FFFF);
        push_request(OP_SEARCH, 10'd0, 32'd5);
        push_request(OP_SEARCH, 10'd0, 32'd0);
        push_request(OP_SEARCH, 10'd0, 32'hFFFF_FFFF);
        push_request(OP_SEARCH, 10'd0, 32'd15);
        push_request(OP_WRITE, '1, 32'h1234_5678);
        // Decreasing by first/last but unsorted inside; key above all steps off entry 0
        push_request(OP_WRITE, 10'd0, 32'h8000_0000);
        push_request(OP_WRITE, 10'd3, 32'd0);
        push_request(OP_SEARCH, 10'd0, 32'hFFFF_FFFF);
        push_request(OP_SEARCH, 10'd0, 32'd20);
        // Full depth: saturated length increasing, exact length decreasing
        spine_test('1, 1'b0);
        spine_test(CFG_W'(DEPTH), 1'b1);

        // Random phases, rotating through the idle mixes
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || phase < 12) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase == 9) len = 11'd2;
            else if ($urandom_range(3) == 0) len = CFG_W'($urandom_range(64, 25));
            else len = CFG_W'($urandom_range(24, 1));
            write_table_length(len);
            n    = answers.used_entries();
            roll = $urandom_range(99);
            if (phase == 1 || roll < 35) shape = SHAPE_INCR;
            else if (phase == 6 || roll < 70) shape = SHAPE_DECR;
            else if (roll < 80) shape = SHAPE_CONST;
            else shape = SHAPE_UNSORTED;
            load_table(n, shape);
            count = $urandom_range(25, 10);
            if (phase == 4) holdoff_ask++;    // results back up while requests keep coming
            for (int k = 0; k < count; k++) begin
                if (phase == 7 && k == count / 2) wait_all_answers();
                if ($urandom_range(99) < 6)
                    push_request(OP_WRITE, IDX_W'($urandom_range(DEPTH - 1)), $urandom);
                else
                    push_request(OP_SEARCH, IDX_W'($urandom_range(DEPTH - 1)), pick_key(n));
                random_items++;
            end
            phase++;
        end

        wait_all_answers();
        if (answers.failures == 0 && answers.pending_answers.size() == 0) begin
            $display("sorted_table_binary_search_top verification clean");
        end else begin
            $display("sorted_table_binary_search_top verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_table.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/sorted_table_binary_search_top.sv
hw/rtl/stbs_checker.sv
tb/tb_sorted_table_binary_search_top.sv
